// File: sv/dfs_pkg.sv
// shared types, constants and calendar helpers for the daily freeze scheduler
`default_nettype none
package dfs_pkg;

    localparam int DFS_BASE_YEAR = 2000;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    localparam logic [YEAR_W-1:0]   YEAR_MAX    = 7'd99;
    localparam logic [MONTH_W-1:0]  MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]    DAY_FIRST   = 5'd1;
    localparam logic [DAY_W-1:0]    DAY_LEAP_FEB = 5'd29;
    localparam logic [HOUR_W-1:0]   HOURS_DAY   = 5'd24;
    localparam logic [MINUTE_W-1:0] MINUTES_HOUR = 6'd60;
    localparam logic [SECOND_W-1:0] SECONDS_MIN = 6'd60;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic                mode;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } dfs_reading_t;

    typedef struct packed {
        logic               freeze;
        logic [YEAR_W-1:0]  freeze_year;
        logic [MONTH_W-1:0] freeze_month;
        logic [DAY_W-1:0]   freeze_day;
        logic               bad_reading;
    } dfs_result_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } dfs_date_t;

    // schedule state held between items
    typedef struct packed {
        dfs_date_t date;
        logic      sched_valid;
    } dfs_sched_t;

    // one leap flag per year offset, built at elaboration
    function automatic logic [2**YEAR_W-1:0] leap_mask(input int base);
        logic [2**YEAR_W-1:0] m;
        int                   y;
        m = '0;
        for (int i = 0; i < 2**YEAR_W; i++) begin
            y    = base + i;
            m[i] = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        end
        return m;
    endfunction

    // month length, zero for a month that does not exist
    function automatic logic [DAY_W-1:0] days_in(input logic leap,
                                                 input logic [MONTH_W-1:0] mon);
        logic [MONTH_W-1:0] idx;
        idx = mon - MONTH_JAN;
        if (mon < MONTH_JAN || mon > MONTH_DEC) begin
            return '0;
        end
        else if (mon == MONTH_FEB && leap) begin
            return DAY_LEAP_FEB;
        end
        return MONTH_LEN[idx];
    endfunction

endpackage
`default_nettype wire

// File: sv/dfs_stream_if.sv
// valid/ready stream channel carrying one payload struct per transfer
`default_nettype none
interface dfs_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/dfs_calc.sv
// combinational check, compare and day step for one registered reading
`default_nettype none
module dfs_calc #(
    parameter int BASE_YEAR = dfs_pkg::DFS_BASE_YEAR
) (
    input  dfs_pkg::dfs_reading_t rd,
    input  dfs_pkg::dfs_sched_t   sched,
    output dfs_pkg::dfs_sched_t   sched_next,
    output dfs_pkg::dfs_result_t  res
);
    import dfs_pkg::*;

    localparam logic [2**YEAR_W-1:0] LEAP = leap_mask(BASE_YEAR);

    logic             leap_now;
    logic [DAY_W-1:0] dim;
    logic             rd_ok;
    logic             midnight;
    logic             resched;
    logic             reached;
    logic [DAY_W:0]   day_inc;
    dfs_date_t        rd_date;
    dfs_date_t        stepped;

    assign leap_now = LEAP[rd.year];
    assign dim      = days_in(leap_now, rd.month);
    assign rd_ok    = (rd.year <= YEAR_MAX) && (rd.month >= MONTH_JAN) &&
                      (rd.month <= MONTH_DEC) && (rd.day >= DAY_FIRST) &&
                      (rd.day <= dim) && (rd.hour < HOURS_DAY) &&
                      (rd.minute < MINUTES_HOUR) && (rd.second < SECONDS_MIN);
    assign midnight = (rd.hour == '0) && (rd.minute == '0) && (rd.second == '0);
    assign resched  = rd.mode || !sched.sched_valid;
    assign rd_date  = '{year: rd.year, month: rd.month, day: rd.day};
    assign reached  = {rd.year, rd.month, rd.day} >=
                      {sched.date.year, sched.date.month, sched.date.day};
    assign day_inc  = {1'b0, rd.day} + {{DAY_W{1'b0}}, 1'b1};

    // day after the reading, with month and year carry
    always_comb
    begin
        stepped = rd_date;
        if (day_inc > {1'b0, dim}) begin
            stepped.day = DAY_FIRST;
            if (rd.month == MONTH_DEC) begin
                stepped.month = MONTH_JAN;
                stepped.year  = (rd.year < YEAR_MAX) ? rd.year + 7'd1 : '0;
            end
            else begin
                stepped.month = rd.month + 4'd1;
            end
        end
        else begin
            stepped.day = day_inc[DAY_W-1:0];
        end
    end

    always_comb
    begin
        res        = '0;
        sched_next = sched;
        if (!rd_ok) begin
            res.bad_reading        = 1'b1;
            sched_next.sched_valid = 1'b0;
        end
        else if (resched) begin
            sched_next.date        = midnight ? rd_date : stepped;
            sched_next.sched_valid = 1'b1;
        end
        else if (reached) begin
            res.freeze       = 1'b1;
            res.freeze_year  = sched.date.year;
            res.freeze_month = sched.date.month;
            res.freeze_day   = sched.date.day;
            sched_next.date  = stepped;
        end
    end

endmodule
`default_nettype wire

// File: sv/daily_freeze_scheduler.sv
// daily freeze scheduler top level: input register, calc, result register
// usage:
//   reading is a valid/ready sink, one clock reading per transfer; mode 0 is a
//   second tick, mode 1 reschedules after the clock was set
//   result is a valid/ready source with exactly one result per reading: a
//   freeze flag with the freeze date, or bad_reading for a bad reading
//   a transferred reading sits in the input register, is evaluated against
//   the stored freeze date and lands in the result register once that
//   register is empty or being read; the result is visible from then on
//   throughput is one reading per cycle while result.ready is high, set by the
//   single calc stage whose schedule update feeds the next reading directly
//   reading.ready stays high while the result register drains or is empty,
//   so a full result register still lets one reading wait in the input
//   register; once it waits and result.ready is low, both hold, ready drops
//   reset clears both valid flags, sets the stored date to offset 0, january
//   1, and marks the schedule stale so the first valid tick reschedules
`default_nettype none
module daily_freeze_scheduler #(
    parameter int BASE_YEAR = dfs_pkg::DFS_BASE_YEAR
) (
    input wire logic clk,
    input wire logic rst_n,
    dfs_stream_if.sink   reading,
    dfs_stream_if.source result
);
    import dfs_pkg::*;

    logic         in_valid_reg;
    dfs_reading_t in_data_reg;
    logic         out_valid_reg;
    dfs_result_t  out_data_reg;
    dfs_sched_t   sched_reg;
    dfs_sched_t   sched_next;
    dfs_result_t  calc_res;
    logic         advance;

    assign advance       = in_valid_reg && (!out_valid_reg || result.ready);
    assign reading.ready = !in_valid_reg || advance;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_data_reg;

    dfs_calc #(
        .BASE_YEAR(BASE_YEAR)
    ) u_calc (
        .rd         (in_data_reg),
        .sched      (sched_reg),
        .sched_next (sched_next),
        .res        (calc_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            sched_reg.date.year   <= '0;
            sched_reg.date.month  <= MONTH_JAN;
            sched_reg.date.day    <= DAY_FIRST;
            sched_reg.sched_valid <= 1'b0;
        end
        else begin
            if (reading.ready) begin
                in_valid_reg <= reading.valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                sched_reg     <= sched_next;
            end
            else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (reading.valid && reading.ready) begin
            in_data_reg <= reading.data;
        end
        if (advance) begin
            out_data_reg <= calc_res;
        end
    end

`ifndef ASSERT_OFF
    a_freeze_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.freeze && out_data_reg.bad_reading))
        else $error("freeze and bad_reading both set");

    a_bad_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && calc_res.bad_reading |=> !sched_reg.sched_valid)
        else $error("invalid reading left schedule valid");

    a_freeze_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.freeze |->
            (out_data_reg.freeze_month >= MONTH_JAN &&
             out_data_reg.freeze_month <= MONTH_DEC))
        else $error("freeze month out of range");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not filled");

    a_sched_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(sched_reg))
        else $error("schedule changed without a reading");
`endif

endmodule
`default_nettype wire
